// ===== sv/lpbg_pkg.sv =====
// lpbg_pkg: shared types, register codes, reset values and the cosine scale function
`timescale 1ns / 1ps

package lpbg_pkg;

    typedef enum logic [1:0] {
        REG_PWM_PERIOD = 2'd0,
        REG_LED_MODE   = 2'd1,
        REG_PHASE_STEP = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        MODE_HIGH_FADE = 3'd0,
        MODE_ON        = 3'd1,
        MODE_OFF       = 3'd2,
        MODE_LOW       = 3'd3,
        MODE_LOW_FADE  = 3'd4
    } led_mode_t;

    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [2:0]  MODE_RESET   = 3'd2;
    localparam logic [15:0] STEP_RESET   = 16'd1043;
    // period/12 and period - period/12 for the reset period
    localparam logic [15:0] DIV12_RESET  = 16'd83;
    localparam logic [15:0] MAX_RESET    = 16'd917;

    // floor(n/3) = (n * 43691) >> 17, exact for 16-bit n
    localparam logic [15:0] RECIP3       = 16'd43691;
    localparam int          RECIP3_SHIFT = 17;

    localparam longint          Q30_ONE     = 64'sd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          COS_DENOM [7] = '{182, 132, 90, 56, 30, 12, 2};

    // (cos + 1) / 2 in Q0.16 for table entry k of a table of 2**lg entries
    function automatic logic [15:0] cos_scale(input int unsigned k, input int unsigned lg);
        longint unsigned f;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned prod;
        longint          t;
        longint          v;
        logic            neg;
        neg = 1'b0;
        t   = Q30_ONE;
        f   = longint'(k) << (32 - lg);
        if (f > 64'h8000_0000)
        begin
            f = 64'h1_0000_0000 - f;
        end
        if (f > 64'h4000_0000)
        begin
            neg = 1'b1;
            f   = 64'h8000_0000 - f;
        end
        x  = (f * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        for (int i = 0; i < 7; i++)
        begin
            prod = (x2 * longint'(t)) >> 30;
            t    = Q30_ONE - longint'(prod) / COS_DENOM[i];
            if (t < 0)
            begin
                t = 0;
            end
            if (t > Q30_ONE)
            begin
                t = Q30_ONE;
            end
        end
        v = (t + 16384) >>> 15;
        if (v > 32767)
        begin
            v = 32767;
        end
        if (neg)
        begin
            v = 32768 - v;
        end
        else
        begin
            v = 32768 + v;
        end
        return v[15:0];
    endfunction

endpackage

// ===== sv/led_pwm_breathing_generator.sv =====
// led_pwm_breathing_generator: top level, config registers, phase memory and width pipeline
//
//  channel | signals                                        | beat
//  --------+------------------------------------------------+------------------------------
//  in      | in_valid, in_ready, tick                       | one update request
//  out     | out_valid, out_ready, pwm_width                | one pwm pulse width
//  config  | psel, penable, pwrite, paddr, pwdata, prdata   | one 32-bit register access
//
//  one beat per clock sustained while out_ready stays high; a beat reaches out_valid through
//  phase memory read at accept, cosine rom read and multiply into the output register
//  the phase sits in a one-entry ram; back-to-back beats take the phase via forwarding
//  reset: phase reads as zero until first written, no clearing pass needed
//  each stage holds under back-pressure; in_ready only falls once all stages are full
`timescale 1ns / 1ps

module led_pwm_breathing_generator #(
    parameter int COS_TABLE_DEPTH = 256,
    parameter int PHASE_BITS      = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        tick,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pwm_width
);

    import lpbg_pkg::*;

    localparam int IDX_W       = $clog2(COS_TABLE_DEPTH);
    localparam int STATE_DEPTH = 1;
    localparam int STATE_AW    = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

    typedef logic [15:0] rom_t [COS_TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < COS_TABLE_DEPTH; k++)
        begin
            r[k] = cos_scale(k, IDX_W);
        end
        return r;
    endfunction

    localparam rom_t SCALE_ROM = build_rom();

    // configuration registers
    logic [15:0] period_reg;
    logic [2:0]  mode_reg;
    logic [15:0] step_reg;
    logic [15:0] div12_reg, div12_next;
    logic [15:0] max_reg, max_next;
    logic [29:0] recip_prod;
    logic        cfg_write;
    reg_idx_t    cfg_sel;

    // pipeline
    logic                  v1_reg, tick1_reg;
    logic                  fwd_valid_reg;
    logic [PHASE_BITS-1:0] fwd_phase_reg;
    logic                  mem_valid_reg;
    logic                  v2_reg;
    logic [15:0]           scale_reg;
    logic                  out_valid_reg;
    logic [15:0]           width_reg, width_next;
    logic [15:0]           last_width_reg;

    logic                  in_accept;
    logic                  out_free, s2_free, s1_free, adv1, adv2;
    logic [PHASE_BITS-1:0] ram_rdata;
    logic [PHASE_BITS-1:0] phase_cur, phase_new, phase_sel;
    logic [PHASE_BITS+15:0] phase_sum;
    logic [IDX_W-1:0]      rom_idx;
    logic [31:0]           fade_prod;
    logic [16:0]           low_fade_sum;

    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_sel   = reg_idx_t'(paddr[3:2]);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            mode_reg   <= MODE_RESET;
            step_reg   <= STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_PWM_PERIOD: period_reg <= pwdata[15:0];
                REG_LED_MODE:   mode_reg   <= pwdata[2:0];
                REG_PHASE_STEP: step_reg   <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_PWM_PERIOD: prdata = {16'd0, period_reg};
            REG_LED_MODE:   prdata = {29'd0, mode_reg};
            REG_PHASE_STEP: prdata = {16'd0, step_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // period/12 as (period/4)/3 by reciprocal, registered ahead of the fade multiply
    assign recip_prod = 30'(period_reg[15:2]) * 30'(RECIP3);
    assign div12_next = 16'(recip_prod[29:RECIP3_SHIFT]);
    assign max_next   = period_reg - div12_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div12_reg <= DIV12_RESET;
            max_reg   <= MAX_RESET;
        end
        else
        begin
            div12_reg <= div12_next;
            max_reg   <= max_next;
        end
    end

    // stage handshakes
    assign out_free  = !out_valid_reg || out_ready;
    assign adv2      = v2_reg && out_free;
    assign s2_free   = !v2_reg || out_free;
    assign adv1      = v1_reg && s2_free;
    assign s1_free   = !v1_reg || s2_free;
    assign in_ready  = s1_free;
    assign in_accept = in_valid && in_ready;

    // phase memory: read on accept, written back as the beat leaves stage one
    lpbg_ram #(
        .WIDTH (PHASE_BITS),
        .DEPTH (STATE_DEPTH)
    ) u_phase_ram (
        .clk   (clk),
        .we    (adv1),
        .waddr (STATE_AW'(0)),
        .wdata (phase_new),
        .re    (in_accept),
        .raddr (STATE_AW'(0)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (fwd_valid_reg)
        begin
            phase_cur = fwd_phase_reg;
        end
        else if (mem_valid_reg)
        begin
            phase_cur = ram_rdata;
        end
        else
        begin
            phase_cur = '0;
        end
        phase_sum = (PHASE_BITS + 16)'(phase_cur) + (PHASE_BITS + 16)'(step_reg);
        phase_new = tick1_reg ? phase_sum[PHASE_BITS-1:0] : phase_cur;
        // high fade runs at twice the phase, wrapping at one turn
        if (mode_reg == MODE_HIGH_FADE)
        begin
            phase_sel = {phase_cur[PHASE_BITS-2:0], 1'b0};
        end
        else
        begin
            phase_sel = phase_cur;
        end
        rom_idx = IDX_W'({phase_sel, {IDX_W{1'b0}}} >> PHASE_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            fwd_valid_reg <= 1'b0;
            mem_valid_reg <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            last_width_reg <= 16'd0;
        end
        else
        begin
            if (s1_free)
            begin
                v1_reg <= in_accept;
            end
            // a write landing with the read means the ram data is one beat old
            if (in_accept)
            begin
                fwd_valid_reg <= adv1;
            end
            if (adv1)
            begin
                mem_valid_reg <= 1'b1;
            end
            if (s2_free)
            begin
                v2_reg <= adv1;
            end
            if (adv2)
            begin
                out_valid_reg  <= 1'b1;
                last_width_reg <= width_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tick1_reg     <= tick;
            fwd_phase_reg <= phase_new;
        end
        if (adv1)
        begin
            scale_reg <= SCALE_ROM[rom_idx];
        end
        if (adv2)
        begin
            width_reg <= width_next;
        end
    end

    // width from mode, limits and scale
    always_comb
    begin
        if (mode_reg == MODE_HIGH_FADE)
        begin
            fade_prod = 32'(max_reg) * 32'(scale_reg);
        end
        else
        begin
            fade_prod = 32'(div12_reg) * 32'(scale_reg);
        end
        low_fade_sum = 17'(fade_prod[31:16]) + 17'(max_reg);
        case (mode_reg)
            MODE_HIGH_FADE: width_next = fade_prod[31:16];
            MODE_ON:        width_next = 16'd0;
            MODE_OFF:       width_next = period_reg;
            MODE_LOW:       width_next = max_reg;
            MODE_LOW_FADE:  width_next = low_fade_sum[15:0];
            default:        width_next = last_width_reg;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign pwm_width = width_reg;

    // a write coinciding with a read must be picked up by the next beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && adv1) |=> fwd_valid_reg)
        else $error("phase forward missed for back-to-back beat");

    // once the phase entry is written it is never treated as unwritten again
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(adv1) |-> mem_valid_reg)
        else $error("phase memory valid flag lost after write");

    // stage two only fills from stage one
    assert property (@(posedge clk) disable iff (!rst_n)
        (!v1_reg && s2_free) |=> !v2_reg)
        else $error("stage two filled without a beat in stage one");

endmodule

// ===== sv/lpbg_ram.sv =====
// lpbg_ram: generic single-port-write ram with registered read
`timescale 1ns / 1ps

module lpbg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== tb/pulse_width_checker.sv =====
// pwm_width_checker: watches the config port and both beat channels, predicts and compares widths
`timescale 1ns / 1ps

module pwm_width_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        tick,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] pwm_width,
    output int          mismatches,
    output int          pending
);

    import lpbg_pkg::*;

    typedef longint unsigned u64_t;

    localparam int     TABLE_DEPTH = 256;
    localparam int     PHASE_W     = 16;
    localparam longint Q30         = 64'sd1073741824;
    localparam u64_t   HALF_PI     = 64'd1686629713;

    logic [15:0] scale_rom [TABLE_DEPTH];

    // shadow registers and state
    logic [15:0] period;
    logic [2:0]  mode;
    logic [15:0] step;
    logic [15:0] phase_acc;
    logic [15:0] last_width;

    logic [15:0] widths_due [$];

    // (cos + 1) / 2 in q0.16 for table entry k, evaluated in q30
    function automatic logic [15:0] half_cos_scale(input int k);
        u64_t   turn;
        u64_t   ang;
        u64_t   ang_sq;
        u64_t   prod;
        longint acc;
        longint rounded;
        logic   negate;
        negate = 1'b0;
        acc    = Q30;
        turn   = (u64_t'(k) << 32) / TABLE_DEPTH;
        if (turn > 64'h8000_0000)
        begin
            turn = 64'h1_0000_0000 - turn;
        end
        if (turn > 64'h4000_0000)
        begin
            negate = 1'b1;
            turn   = 64'h8000_0000 - turn;
        end
        ang    = (turn * HALF_PI) >> 30;
        ang_sq = (ang * ang) >> 30;
        // horner steps of the taylor series, divisors 14*13 down to 2*1
        for (int n = 7; n >= 1; n--)
        begin
            prod = (ang_sq * u64_t'(acc)) >> 30;
            acc  = Q30 - longint'(prod) / longint'(2 * n * (2 * n - 1));
            if (acc < 0)
            begin
                acc = 0;
            end
            if (acc > Q30)
            begin
                acc = Q30;
            end
        end
        rounded = (acc + 16384) >>> 15;
        if (rounded > 32767)
        begin
            rounded = 32767;
        end
        return negate ? 16'(32768 - rounded) : 16'(32768 + rounded);
    endfunction

    function automatic logic [15:0] scale_at(input logic [15:0] ph);
        return scale_rom[(u64_t'(ph) * TABLE_DEPTH) >> PHASE_W];
    endfunction

    function automatic logic [15:0] predict_width();
        logic [15:0] top_lim;
        logic [15:0] doubled;
        logic [31:0] prod;
        top_lim = period - period / 12;
        doubled = {phase_acc[14:0], 1'b0};
        case (mode)
            MODE_HIGH_FADE:
            begin
                prod = 32'(top_lim) * 32'(scale_at(doubled));
                return prod[31:16];
            end
            MODE_ON:
            begin
                return '0;
            end
            MODE_OFF:
            begin
                return period;
            end
            MODE_LOW:
            begin
                return top_lim;
            end
            MODE_LOW_FADE:
            begin
                prod = 32'(period - top_lim) * 32'(scale_at(phase_acc));
                return prod[31:16] + top_lim;
            end
            default:
            begin
                // spare mode codes hold the previous width
                return last_width;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t pwm_width_checker: %s", $time, what);
    endtask

    initial
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            scale_rom[k] = half_cos_scale(k);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [15:0] w;
        if (!rst_n)
        begin
            period     = PERIOD_RESET;
            mode       = MODE_RESET;
            step       = STEP_RESET;
            phase_acc  = '0;
            last_width = '0;
            widths_due.delete();
            pending   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (widths_due.size() == 0)
                begin
                    report_mismatch($sformatf("pwm_width %0d with no beat waiting",
                                              pwm_width));
                end
                else
                begin
                    w = widths_due.pop_front();
                    if (pwm_width !== w)
                    begin
                        report_mismatch($sformatf("pwm_width %0d, expected %0d",
                                                  pwm_width, w));
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_PWM_PERIOD: period = pwdata[15:0];
                    REG_LED_MODE:   mode   = pwdata[2:0];
                    REG_PHASE_STEP: step   = pwdata[15:0];
                    default:        ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                w          = predict_width();
                last_width = w;
                widths_due.push_back(w);
                // phase moves on only after the width is formed
                if (tick)
                begin
                    phase_acc = phase_acc + step;
                end
            end
            pending <= widths_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// testbench: clock, reset, config writes and beat stimulus around the breathing pwm block
`timescale 1ns / 1ps

module testbench;

    import lpbg_pkg::*;

    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int         RANDOM_PHASES = 16;
    localparam int         SETTLE_CYCLES = 5;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic        in_valid  = 1'b0;
    logic        tick      = 1'b0;
    logic        out_ready = 1'b0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_ready;
    logic        out_valid;
    logic [15:0] pwm_width;
    int          mismatches;
    int          pending;
    bit          no_gaps = 1'b0;

    always #1 clk = ~clk;

    led_pwm_breathing_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .tick      (tick),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pwm_width (pwm_width)
    );

    pwm_width_checker pw_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .tick       (tick),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pwm_width  (pwm_width),
        .mismatches (mismatches),
        .pending    (pending)
    );

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_beat(input logic t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        tick     <= t;
        do @(posedge clk); while (!in_ready);
    endtask

    // wait for every width to come back, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [15:0] period, input logic [2:0] mode,
                             input logic [15:0] step, input int beats);
        write_reg(REG_PWM_PERIOD, {16'($urandom()), period});
        write_reg(REG_LED_MODE, {29'($urandom()), mode});
        write_reg(REG_PHASE_STEP, {16'($urandom()), step});
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (beats) send_beat($urandom_range(0, 3) != 0);
        drain();
    endtask

    initial
    begin
        logic [15:0] period;
        logic [15:0] step;
        logic [2:0]  mode;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // spare mode before any beat: width holds its reset value of zero
        write_reg(REG_LED_MODE, {29'($urandom()), MODE_SPARE_LO});
        send_beat(1'b1);
        send_beat(1'b0);
        drain();

        run_phase(PERIOD_RESET, MODE_ON, STEP_RESET, 1);
        run_phase('1, MODE_OFF, STEP_RESET, 1);
        run_phase('1, MODE_LOW, '0, 1);
        // zero period gives zero in every mode but the spare codes
        run_phase('0, MODE_LOW, '0, 1);
        run_phase('0, MODE_HIGH_FADE, STEP_RESET, 1);
        run_phase('0, MODE_LOW_FADE, STEP_RESET, 1);
        // full-scale step wraps the accumulator every tick
        run_phase('1, MODE_HIGH_FADE, '1, 3);
        run_phase('1, MODE_LOW_FADE, 16'd16384, 5);
        run_phase(16'd12, MODE_SPARE_HI, 16'd1, 2);
        run_phase(16'd1, MODE_HIGH_FADE, 16'd32768, 2);

        // unmapped register must be ignored
        write_reg(REG_UNUSED, $urandom());
        send_beat(1'b1);
        send_beat(1'b1);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 7))
                0:       period = '0;
                1:       period = 16'd1;
                2:       period = '1;
                default: period = 16'($urandom());
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mode = MODE_HIGH_FADE;
                4, 5, 6, 7: mode = MODE_LOW_FADE;
                8:          mode = 3'($urandom_range(MODE_ON, MODE_LOW));
                default:    mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            endcase
            case ($urandom_range(0, 5))
                0:       step = '0;
                1:       step = '1;
                2:       step = 16'($urandom_range(1, 64));
                default: step = 16'($urandom());
            endcase
            run_phase(period, mode, step, $urandom_range(20, 40));
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // receiver side: random stall before each beat unless no_gaps is set
    initial
    begin
        int stall;
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        #200000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
